// ----- hdl/rrfr_pkg.sv -----
// Package for the ray reflect/refract unit: fixed-point constants and the
// pipeline stage record. No dependencies.
package rrfr_pkg;

  localparam int FRAC      = 16;                // fraction bits of direction components
  localparam int FIELD_W   = 20;                // width of a direction component
  localparam int ETA_W     = 17;                // width of the index ratio
  localparam logic [ETA_W-1:0] ETA_RESET = 17'd54613;  // 1/1.2 in Q1.16
  localparam int SQ_W      = 40;                // radicand width of the square root
  localparam int SQ_STEPS  = SQ_W / 2;          // one result bit per stage
  localparam int IN_DATA_W  = 120;              // six components
  localparam int OUT_DATA_W = 64;               // three components padded to bytes

  typedef logic signed [FIELD_W-1:0] comp_t;

  typedef struct {
    logic              mode;
    logic              tir;
    comp_t             d    [3];
    comp_t             n    [3];
    logic signed [37:0] edr [3];   // eta * d, unrounded
    logic signed [39:0] p   [3];   // d * n per component
    logic signed [41:0] dot;
    logic signed [45:0] ph  [3];   // dot high part * n
    logic signed [36:0] pl  [3];   // dot low part * n
    logic signed [18:0] ci;
    logic signed [31:0] refl [3];
    logic signed [37:0] cc;
    logic signed [36:0] eci_raw;
    logic signed [19:0] q;
    logic signed [20:0] eci;
    logic signed [37:0] t1;
    logic signed [21:0] r1;
    logic signed [39:0] t2;
    logic [SQ_W-1:0]    x;
    logic [SQ_W-1:0]    res;
    logic signed [22:0] k;
    logic signed [42:0] kn  [3];
    comp_t             o    [3];
  } pipe_t;

endpackage

// ----- hdl/ray_reflect_refract_unit.sv -----
// Ray reflect/refract unit: top level, a single pipelined datapath.
// Depends on rrfr_pkg for constants and the stage record.

// The unit takes one ray per clock unless the pipe holds, and returns one result
// per ray, in order. The pipeline has nine stages of products and rounding for
// the dot product, the cosine and sin^2(t), twenty stages of the bit-per-stage
// square root, and three stages for the final scale, sum and saturation. The
// whole pipe advances together and holds while the output register is full and
// not taken, so in_tready follows out_tready when the last stage holds a result.
// The index ratio is written through the cfg channel, which is always ready;
// write it only while no ray is in flight. Reflect mode never raises
// total_reflection.
module ray_reflect_refract_unit
  import rrfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // config channel: index_ratio [16:0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ETA_W-1:0]      cfg_data,
  // in_tdata: dir_x[19:0] dir_y[39:20] dir_z[59:40] norm_x[79:60] norm_y[99:80] norm_z[119:100]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode[0]
  input  logic [0:0]            in_tuser,
  // out_tdata: out_x[19:0] out_y[39:20] out_z[59:40], zero pad above
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: total_reflection[0]
  output logic [0:0]            out_tuser
);

  localparam int ST_S9  = 8;
  localparam int ST_SQ0 = 9;
  localparam int ST_K   = ST_SQ0 + SQ_STEPS;
  localparam int ST_KN  = ST_K + 1;
  localparam int ST_OUT = ST_KN + 1;
  localparam int NS     = ST_OUT + 1;

  logic [ETA_W-1:0]   eta_r;
  logic signed [17:0] eta_s;
  pipe_t              stg_r   [NS];
  pipe_t              stg_nxt [NS];
  logic [NS-1:0]      vld_r;
  logic               en;

  assign eta_s     = $signed({1'b0, eta_r});
  assign cfg_ready = 1'b1;

  // Advance every stage at once unless the output holds an untaken result.
  assign en         = !vld_r[NS-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {{(OUT_DATA_W-3*FIELD_W){1'b0}},
                       stg_r[NS-1].o[2], stg_r[NS-1].o[1], stg_r[NS-1].o[0]};
  assign out_tuser  = stg_r[NS-1].tir;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_r <= ETA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eta_r <= cfg_data;
    end
  end

  // Stage 0: unpack, component products and eta * d.
  always_comb begin
    stg_nxt[0]      = stg_r[0];
    stg_nxt[0].mode = in_tuser[0];
    stg_nxt[0].tir  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      stg_nxt[0].d[i]   = $signed(in_tdata[FIELD_W*i +: FIELD_W]);
      stg_nxt[0].n[i]   = $signed(in_tdata[3*FIELD_W + FIELD_W*i +: FIELD_W]);
      stg_nxt[0].p[i]   = 40'(stg_nxt[0].d[i]) * 40'(stg_nxt[0].n[i]);
      stg_nxt[0].edr[i] = 38'(eta_s) * 38'(stg_nxt[0].d[i]);
    end
  end

  // Stage 1: exact dot product.
  always_comb begin
    stg_nxt[1]     = stg_r[0];
    stg_nxt[1].dot = 42'(stg_r[0].p[0]) + 42'(stg_r[0].p[1]) + 42'(stg_r[0].p[2]);
  end

  // Stage 2: split products for reflect, rounded and clamped cosine.
  always_comb begin
    logic signed [42:0] ndot;
    logic signed [42:0] rc;
    stg_nxt[2] = stg_r[1];
    for (int i = 0; i < 3; i++) begin
      stg_nxt[2].ph[i] = 46'($signed(stg_r[1].dot[41:16])) * 46'(stg_r[1].n[i]);
      stg_nxt[2].pl[i] = 37'($signed({1'b0, stg_r[1].dot[15:0]})) * 37'(stg_r[1].n[i]);
    end
    ndot = -(43'(stg_r[1].dot));
    rc   = (ndot + 43'sd32768) >>> FRAC;
    if (rc > 43'sd131072) begin
      stg_nxt[2].ci = 19'sd131072;
    end else if (rc < -43'sd131072) begin
      stg_nxt[2].ci = -19'sd131072;
    end else begin
      stg_nxt[2].ci = 19'(rc);
    end
  end

  // Stage 3: reflect result, cos^2 and eta * cos.
  always_comb begin
    logic signed [63:0] acc;
    stg_nxt[3] = stg_r[2];
    for (int i = 0; i < 3; i++) begin
      acc = (64'(stg_r[2].ph[i]) <<< 17) + (64'(stg_r[2].pl[i]) <<< 1)
            + 64'sd2147483648;
      stg_nxt[3].refl[i] = 32'(stg_r[2].d[i]) - 32'(acc >>> 32);
    end
    stg_nxt[3].cc      = 38'(stg_r[2].ci) * 38'(stg_r[2].ci);
    stg_nxt[3].eci_raw = 37'(eta_s) * 37'(stg_r[2].ci);
  end

  // Stage 4: q = 1 - cos^2, round eta * cos.
  always_comb begin
    stg_nxt[4]     = stg_r[3];
    stg_nxt[4].q   = 20'sd65536 - 20'((stg_r[3].cc + 38'sd32768) >>> FRAC);
    stg_nxt[4].eci = 21'((stg_r[3].eci_raw + 37'sd32768) >>> FRAC);
  end

  always_comb begin
    stg_nxt[5]    = stg_r[4];
    stg_nxt[5].t1 = 38'(eta_s) * 38'(stg_r[4].q);
  end

  always_comb begin
    stg_nxt[6]    = stg_r[5];
    stg_nxt[6].r1 = 22'((stg_r[5].t1 + 38'sd32768) >>> FRAC);
  end

  always_comb begin
    stg_nxt[7]    = stg_r[6];
    stg_nxt[7].t2 = 40'(eta_s) * 40'(stg_r[6].r1);
  end

  // Stage 8: sin^2(t), total reflection test, radicand for the root.
  always_comb begin
    logic signed [23:0] s;
    logic signed [24:0] om;
    stg_nxt[ST_S9]     = stg_r[7];
    s                  = 24'((stg_r[7].t2 + 40'sd32768) >>> FRAC);
    om                 = 25'sd65536 - 25'(s);
    stg_nxt[ST_S9].tir = stg_r[7].mode && (s > 24'sd65536);
    stg_nxt[ST_S9].x   = stg_nxt[ST_S9].tir ? '0 : {om[23:0], 16'b0};
    stg_nxt[ST_S9].res = '0;
  end

  // Square root, one result bit per stage.
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2*j);
    always_comb begin
      logic [SQ_W-1:0] t;
      stg_nxt[ST_SQ0+j] = stg_r[ST_SQ0+j-1];
      t = stg_r[ST_SQ0+j-1].res + BIT;
      if (stg_r[ST_SQ0+j-1].x >= t) begin
        stg_nxt[ST_SQ0+j].x   = stg_r[ST_SQ0+j-1].x - t;
        stg_nxt[ST_SQ0+j].res = (stg_r[ST_SQ0+j-1].res >> 1) + BIT;
      end else begin
        stg_nxt[ST_SQ0+j].res = stg_r[ST_SQ0+j-1].res >> 1;
      end
    end
  end

  always_comb begin
    stg_nxt[ST_K]   = stg_r[ST_K-1];
    stg_nxt[ST_K].k = 23'(stg_r[ST_K-1].eci)
                      - $signed({2'b0, stg_r[ST_K-1].res[20:0]});
  end

  always_comb begin
    stg_nxt[ST_KN] = stg_r[ST_K];
    for (int i = 0; i < 3; i++) begin
      stg_nxt[ST_KN].kn[i] = 43'(stg_r[ST_K].k) * 43'(stg_r[ST_K].n[i]);
    end
  end

  // Output stage: pick the result by mode and flag, then saturate.
  always_comb begin
    logic signed [21:0] e;
    logic signed [26:0] m;
    logic signed [31:0] v;
    stg_nxt[ST_OUT] = stg_r[ST_KN];
    for (int i = 0; i < 3; i++) begin
      e = 22'((stg_r[ST_KN].edr[i] + 38'sd32768) >>> FRAC);
      m = 27'((stg_r[ST_KN].kn[i] + 43'sd32768) >>> FRAC);
      if (!stg_r[ST_KN].mode) begin
        v = stg_r[ST_KN].refl[i];
      end else if (stg_r[ST_KN].tir) begin
        v = 32'(stg_r[ST_KN].d[i]);
      end else begin
        v = 32'(e) + 32'(m);
      end
      if (v > 32'sd524287) begin
        stg_nxt[ST_OUT].o[i] = 20'sd524287;
      end else if (v < -32'sd524288) begin
        stg_nxt[ST_OUT].o[i] = -20'sd524288;
      end else begin
        stg_nxt[ST_OUT].o[i] = 20'(v);
      end
    end
  end

  // Payload registers take no reset; valid bits do.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  // A flagged result passes the direction through unchanged.
  a_tir_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      stg_r[NS-1].o[0] == stg_r[NS-1].d[0] && stg_r[NS-1].o[1] == stg_r[NS-1].d[1]
      && stg_r[NS-1].o[2] == stg_r[NS-1].d[2])
    else $error("total reflection result differs from direction");

  // Reflect items never carry the flag.
  a_reflect_noflag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !stg_r[NS-1].mode |-> !out_tuser[0])
    else $error("reflect result flagged as total reflection");

  // Total reflection feeds a zero radicand into the root.
  a_tir_rad: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_S9] && stg_r[ST_S9].tir |-> stg_r[ST_S9].x == '0)
    else $error("nonzero radicand on total reflection");

endmodule

// ----- sim/ray_reflect_refract_unit_test.sv -----
// Testbench for ray_reflect_refract_unit: directed and random rays in both modes,
// several index ratios and handshake pressure patterns, checked against a predictor.
// Depends on rrfr_pkg and the unit's RTL.
module ray_reflect_refract_unit_test;
  import rrfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_REFLECT = 1'b0;
  localparam logic MODE_REFRACT = 1'b1;
  localparam int LATENCY = 32;
  localparam int ONE = 1 << FRAC;

  typedef struct packed {
    logic        mode;
    logic [19:0] dx, dy, dz, nx, ny, nz;
  } ray_t;

  typedef struct packed {
    logic [19:0] ox, oy, oz;
    logic        tir;
  } bend_t;

  // directed rows: known result typed in only where obvious
  typedef struct {
    ray_t  ray;
    logic  known;
    bend_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ETA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // dir_x dir_y dir_z norm_x norm_y norm_z, 20 bits each
  logic [0:0] in_tuser = '0;             // mode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // out_x out_y out_z, zero pad above
  logic [0:0] out_tuser;                 // total_reflection

  ray_reflect_refract_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [ETA_W-1:0] eta_q = ETA_RESET;
  bend_t bend_q[$];
  int errors = 0;
  int n_results = 0, n_tir = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off = 0;

  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [19:0] clip20(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[19:0];
  endfunction

  function automatic longint root_floor(longint x);
    longint r = 0, b = longint'(1) << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // Predict the bent direction for one ray under the current ratio.
  function automatic bend_t bend_ray(ray_t r);
    longint d[3], n[3], o[3];
    longint dot, eta, ci, q, s, cost, k;
    bend_t b;
    d[0] = longint'($signed(r.dx)); d[1] = longint'($signed(r.dy));
    d[2] = longint'($signed(r.dz));
    n[0] = longint'($signed(r.nx)); n[1] = longint'($signed(r.ny));
    n[2] = longint'($signed(r.nz));
    dot = d[0]*n[0] + d[1]*n[1] + d[2]*n[2];
    b.tir = 1'b0;
    if (r.mode == MODE_REFLECT) begin
      for (int i = 0; i < 3; i++) o[i] = d[i] - rnd_shr(2*dot*n[i], 2*FRAC);
    end else begin
      eta = longint'(eta_q);
      ci = rnd_shr(-dot, FRAC);
      if (ci > 2*ONE) ci = 2*ONE;
      if (ci < -2*ONE) ci = -2*ONE;
      q = ONE - rnd_shr(ci*ci, FRAC);
      s = rnd_shr(eta * rnd_shr(eta*q, 16), 16);
      if (s > ONE) begin
        b.tir = 1'b1;
        for (int i = 0; i < 3; i++) o[i] = d[i];
      end else begin
        cost = root_floor((ONE - s) << FRAC);
        k = rnd_shr(eta*ci, 16) - cost;
        for (int i = 0; i < 3; i++) o[i] = rnd_shr(eta*d[i], 16) + rnd_shr(k*n[i], FRAC);
      end
    end
    b.ox = clip20(o[0]); b.oy = clip20(o[1]); b.oz = clip20(o[2]);
    return b;
  endfunction

  // Drive one ray; hold until the transfer, with random sender gaps.
  task automatic send_ray(ray_t r, logic known, bend_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.mode;
    in_tdata <= {r.nz, r.ny, r.nx, r.dz, r.dy, r.dx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bend_q.push_back(known ? want : bend_ray(r));
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (bend_q.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        bend_t w;
        w = bend_q.pop_front();
        n_results++;
        if (w.tir) n_tir++;
        if (out_tdata[19:0] !== w.ox) begin
          $error("out_x expected %h got %h", w.ox, out_tdata[19:0]); errors++;
        end
        if (out_tdata[39:20] !== w.oy) begin
          $error("out_y expected %h got %h", w.oy, out_tdata[39:20]); errors++;
        end
        if (out_tdata[59:40] !== w.oz) begin
          $error("out_z expected %h got %h", w.oz, out_tdata[59:40]); errors++;
        end
        if (out_tuser[0] !== w.tir) begin
          $error("total_reflection expected %b got %b", w.tir, out_tuser[0]); errors++;
        end
      end
    end
  end

  // Wait out the pipe, then write the ratio while idle.
  task automatic drain_and_set_ratio(logic [ETA_W-1:0] v);
    in_tvalid <= 1'b0;
    while (bend_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    eta_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [19:0] rnd_comp();
    case ($urandom_range(5))
      0: return 20'($urandom());                                  // any bit pattern
      1: return ($urandom_range(1) != 0) ? 20'h80000 : 20'h7FFFF;  // extremes
      default: return 20'($signed($urandom_range(2*ONE)) - ONE);  // unit-ish range
    endcase
  endfunction

  // Mostly near-unit, well-formed rays so refraction goes both ways.
  function automatic ray_t rnd_ray();
    ray_t r;
    r.mode = 1'($urandom_range(1));
    r.dx = rnd_comp(); r.dy = rnd_comp(); r.dz = rnd_comp();
    r.nx = rnd_comp(); r.ny = rnd_comp(); r.nz = rnd_comp();
    if ($urandom_range(3) != 0) begin
      // normal along one axis, direction nearly opposite to it
      r.nx = '0; r.ny = '0; r.nz = '0;
      r.dz = 20'($signed(-$urandom_range(ONE)));
      r.dx = 20'($signed($urandom_range(2*ONE)) - ONE);
      r.dy = 20'($signed($urandom_range(ONE/2)) - ONE/4);
      r.nz = 20'(ONE);
    end
    return r;
  endfunction

  row_t rows[$];
  logic [ETA_W-1:0] ratios[6] = '{ETA_RESET, 17'd0, 17'h1FFFF, 17'd65536, 17'd98304, 17'd30000};

  initial begin
    bend_t none;
    row_t rw;
    none = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    rw.known = 1'b1;
    rw.ray = '{MODE_REFLECT, 0, 0, 0, 0, 0, 0};
    rw.want = '0; rows.push_back(rw);
    // zero normal in reflect: direction passes unchanged
    rw.ray = '{MODE_REFLECT, 20'h7FFFF, 20'h80000, 20'h00001, 0, 0, 0};
    rw.want = '{20'h7FFFF, 20'h80000, 20'h00001, 1'b0}; rows.push_back(rw);
    // reflect straight back off a unit normal
    rw.ray = '{MODE_REFLECT, 0, 0, 20'($signed(-ONE)), 0, 0, 20'(ONE)};
    rw.want = '{20'h0, 20'h0, 20'(ONE), 1'b0}; rows.push_back(rw);
    rw.known = 1'b0;
    rw.ray = '{MODE_REFRACT, 0, 0, 20'($signed(-ONE)), 0, 0, 20'(ONE)}; rows.push_back(rw);
    rw.ray = '{MODE_REFRACT, 20'(ONE), 0, 0, 0, 0, 20'(ONE)}; rows.push_back(rw);
    rw.ray = '{MODE_REFRACT, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF,
               20'h7FFFF, 20'h7FFFF, 20'h7FFFF}; rows.push_back(rw);
    rw.ray = '{MODE_REFRACT, 20'h80000, 20'h80000, 20'h80000,
               20'h7FFFF, 20'h7FFFF, 20'h7FFFF}; rows.push_back(rw);
    rw.ray = '{MODE_REFLECT, 20'h80000, 20'h80000, 20'h80000,
               20'h80000, 20'h80000, 20'h80000}; rows.push_back(rw);
    rw.ray = '{MODE_REFRACT, 20'h12345, 20'h6789A, 20'hBCDEF,
               20'h55555, 20'hAAAAA, 20'h0F0F0}; rows.push_back(rw);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].want);

    // random phases over ratios and idle patterns
    for (int p = 0; p < 24; p++) begin
      drain_and_set_ratio(ratios[p % 6]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (p == 2) hold_off = 200;   // back up the pipe and stall the input
      for (int i = 0; i < 84; i++) send_ray(rnd_ray(), 1'b0, none);
    end

    in_tvalid <= 1'b0;
    while (bend_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    $display("covered %0d rays in both modes over 6 index ratios, %0d with total reflection",
             n_results, n_tir);
    if (errors == 0) $display("[ray_reflect_refract_unit] OK");
    else $display("[ray_reflect_refract_unit] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("[ray_reflect_refract_unit] ERROR");
    $finish;
  end
endmodule
